[src/glzw_pkg.sv]
package glzw_pkg;

	localparam int CodeBits = 12;
	localparam int PixBits  = 9;
	localparam int AccBits  = 48;
	localparam int CntBits  = 6;
	localparam int OutCap   = 5;

	// front-to-back queue item
	typedef struct packed {
		logic [PixBits-1:0] pixel;
		logic               eoi;
	} item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_RD,
		ST_CHK,
		ST_WR,
		ST_EOI,
		ST_OUT
	} back_state_t;

	// dictionary slot: valid code, prior code, pixel
	typedef struct packed {
		logic [CodeBits-1:0] code;
		logic [CodeBits-1:0] prior;
		logic [PixBits-1:0]  pix;
	} slot_t;

	localparam int SlotBits = $bits(slot_t);

endpackage

[src/glzw_ram.sv]
module glzw_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/glzw_front.sv]
module glzw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  glzw_pkg::item_t      in_item,
	output logic                 q_valid,
	input  logic                 q_ready,
	output glzw_pkg::item_t      q_item
);

	// two-entry queue
	glzw_pkg::item_t ent_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");

endmodule

[src/glzw_back.sv]
module glzw_back #(
	parameter int HashSlots = 5003
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [3:0]           min_code_size,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  glzw_pkg::item_t      q_item,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [7:0]           m_byte,
	output logic                 m_last
);

	localparam int AW = $clog2(HashSlots);
	localparam int CB = glzw_pkg::CodeBits;
	localparam int TopCode = (1 << CB) - 1;
	localparam logic [AW:0] SlotsW = (AW+1)'(HashSlots);

	glzw_pkg::back_state_t st_q, st_d;

	logic [AW-1:0]  clr_q;
	logic           clr_eoi_q;
	logic [CB-1:0]  epoch_q;
	logic [AW-1:0]  hx_q;
	logic [AW:0]    d_q;
	logic [AW:0]    k_q;
	logic           fnd_q;
	logic [AW-1:0]  free_q;
	logic [CB-1:0]  prefix_q;
	logic [CB:0]    nfc_q;
	logic [3:0]     cw_q;
	logic [CB:0]    lim_q;
	logic [3:0]     root_q;
	logic [glzw_pkg::AccBits-1:0] acc_q;
	logic [glzw_pkg::CntBits-1:0] bc_q;
	logic           started_q;
	logic [2:0]     nout_q;
	logic [8:0]     px_q;
	logic           eoi_q;
	logic [15:0]    hraw_q;

	// ram: entry tag by epoch to skip reclears after restart
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [CB+glzw_pkg::SlotBits-1:0] wdata, rdata;
	logic [AW-1:0]         raddr;

	glzw_ram #(.Width(CB + glzw_pkg::SlotBits), .Depth(HashSlots)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	glzw_pkg::slot_t rslot;
	logic [CB-1:0]   rep;
	assign {rep, rslot} = rdata;
	logic r_empty;
	assign r_empty = (rslot.code == '0) || (rep != epoch_q);

	// tag about to wrap at an image start: clear the table first
	logic wrap_start;
	assign wrap_start = !started_q && (epoch_q == '1);

	logic [3:0] eff_root;
	always_comb begin
		if (min_code_size < 4'd2)      eff_root = 4'd2;
		else if (min_code_size > 4'd9) eff_root = 4'd9;
		else                           eff_root = min_code_size;
	end

	function automatic logic [CB-1:0] mask_code(input logic [CB-1:0] c, input logic [3:0] w);
		logic [CB-1:0] m;
		m = CB'((13'd1 << w) - 13'd1);
		return c & m;
	endfunction

	// codes enter the accumulator through put, put_code and put_w
	logic           put;
	logic [CB-1:0]  put_code;
	logic [3:0]     put_w;

	logic [AW:0] hx_next;
	logic [AW+1:0] hsum;
	logic [AW+1:0] dsum;
	always_comb begin
		hsum = (AW+2)'(hx_q) + (AW+2)'(d_q);
		if (hsum >= (AW+2)'(HashSlots)) hsum = hsum - (AW+2)'(HashSlots);
		if (hsum >= (AW+2)'(HashSlots)) hsum = hsum - (AW+2)'(HashSlots);
		hx_next = hsum[AW:0];
		dsum = (AW+2)'(d_q) + (AW+2)'(2);
		if (dsum >= (AW+2)'(2*HashSlots)) dsum = dsum - (AW+2)'(2*HashSlots);
	end

	// hash: raw < 2^14, reduce by repeated subtract of constant multiples
	logic [15:0] hred;
	always_comb begin
		hred = hraw_q;
		for (int i = 3; i >= 0; i--) begin
			if (32'(hred) >= (HashSlots << i)) hred = hred - 16'(HashSlots << i);
		end
	end

	assign q_ready = (st_q == glzw_pkg::ST_IDLE) && !wrap_start;
	assign m_valid = (st_q == glzw_pkg::ST_OUT) && bc_q >= 6'd8 && nout_q < 3'(glzw_pkg::OutCap);
	assign m_byte  = acc_q[7:0];
	assign m_last  = (bc_q < 6'd16) || (nout_q == 3'(glzw_pkg::OutCap - 1));

	always_comb begin
		st_d = st_q;
		we = 1'b0;
		waddr = free_q;
		wdata = {epoch_q, CB'(nfc_q), prefix_q, px_q};
		raddr = hx_q;
		put = 1'b0;
		put_code = prefix_q;
		put_w = cw_q;
		unique case (st_q)
			glzw_pkg::ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == AW'(HashSlots - 1))
					st_d = clr_eoi_q ? glzw_pkg::ST_EOI : glzw_pkg::ST_IDLE;
			end
			glzw_pkg::ST_IDLE: begin
				if (wrap_start) st_d = glzw_pkg::ST_CLEAR;
				else if (q_valid) st_d = glzw_pkg::ST_HASH;
			end
			glzw_pkg::ST_HASH: st_d = started_q ? glzw_pkg::ST_RD : glzw_pkg::ST_EOI;
			glzw_pkg::ST_RD: st_d = glzw_pkg::ST_CHK;
			glzw_pkg::ST_CHK: begin
				if (r_empty) st_d = glzw_pkg::ST_WR;
				else if (rslot.prior == prefix_q && 9'(rslot.pix) == px_q) st_d = glzw_pkg::ST_EOI;
				else if (k_q + 1'b1 == SlotsW) st_d = glzw_pkg::ST_WR;
				else st_d = glzw_pkg::ST_RD;
				raddr = hx_next[AW-1:0];
			end
			glzw_pkg::ST_WR: begin
				put = 1'b1;
				we = fnd_q && (nfc_q <= (CB+1)'(TopCode));
				st_d = (nfc_q == lim_q && cw_q == 4'(CB) && epoch_q == '1) ?
					glzw_pkg::ST_CLEAR : glzw_pkg::ST_EOI;
			end
			glzw_pkg::ST_EOI: begin
				if (eoi_q && nout_q == 3'd0) begin
					put = 1'b1;
				end else if (eoi_q && nout_q == 3'd1) begin
					put = 1'b1;
					put_code = CB'((13'd1 << root_q) + 13'd1);
				end
				if (!eoi_q || nout_q == 3'd1) st_d = glzw_pkg::ST_OUT;
			end
			glzw_pkg::ST_OUT: begin
				if (!m_valid || (m_ready && m_last)) st_d = glzw_pkg::ST_IDLE;
			end
			default: st_d = glzw_pkg::ST_IDLE;
		endcase
	end

	logic [glzw_pkg::AccBits-1:0] acc_put;
	assign acc_put = acc_q | (glzw_pkg::AccBits'(mask_code(put_code, put_w)) << bc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= glzw_pkg::ST_CLEAR;
			clr_q <= '0;
			clr_eoi_q <= 1'b0;
			epoch_q <= CB'(1);
			started_q <= 1'b0;
			acc_q <= '0;
			bc_q <= '0;
			prefix_q <= '0;
			nfc_q <= '0;
			cw_q <= 4'd9;
			lim_q <= '0;
			root_q <= 4'd8;
			nout_q <= '0;
			hx_q <= '0; d_q <= '0; k_q <= '0; fnd_q <= 1'b0; free_q <= '0;
			px_q <= '0; eoi_q <= 1'b0; hraw_q <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				glzw_pkg::ST_CLEAR: begin
					if (clr_q == AW'(HashSlots - 1)) clr_q <= '0;
					else clr_q <= clr_q + 1'b1;
				end
				glzw_pkg::ST_IDLE: if (wrap_start) begin
					epoch_q <= '0;
					clr_eoi_q <= 1'b0;
				end else if (q_valid) begin
					logic [3:0] r;
					logic [8:0] p;
					r = started_q ? root_q : eff_root;
					p = q_item.pixel & 9'((10'd1 << r) - 10'd1);
					px_q <= p;
					eoi_q <= q_item.eoi;
					nout_q <= '0;
					hraw_q <= 16'(prefix_q) ^ (16'(p) << 5);
					if (!started_q) begin
						root_q <= r;
						cw_q <= r + 4'd1;
						nfc_q <= (CB+1)'((13'd1 << r) + 13'd2);
						lim_q <= 13'd1 << (r + 4'd1);
						epoch_q <= epoch_q + 1'b1;
						acc_q <= acc_q | (glzw_pkg::AccBits'(13'd1 << r) << bc_q);
						bc_q <= bc_q + 6'(r + 4'd1);
					end
				end
				glzw_pkg::ST_HASH: begin
					if (!started_q) begin
						prefix_q <= CB'(px_q);
						started_q <= 1'b1;
					end
					hx_q <= hred[AW-1:0];
					d_q <= (AW+1)'(1);
					k_q <= '0;
					fnd_q <= 1'b0;
				end
				glzw_pkg::ST_RD: ;
				glzw_pkg::ST_CHK: begin
					if (r_empty) begin
						fnd_q <= 1'b1;
						free_q <= hx_q;
					end else if (rslot.prior == prefix_q && 9'(rslot.pix) == px_q) begin
						prefix_q <= rslot.code;
					end else begin
						hx_q <= hx_next[AW-1:0];
						d_q <= dsum[AW:0];
						k_q <= k_q + 1'b1;
					end
				end
				glzw_pkg::ST_WR: begin
					if (nfc_q == lim_q && cw_q == 4'(CB)) begin
						// full width: clear code follows the prefix, table restarts
						acc_q <= acc_put |
							(glzw_pkg::AccBits'(13'd1 << root_q) << (bc_q + 6'(cw_q)));
						bc_q <= bc_q + 6'(cw_q) + 6'(cw_q);
						cw_q <= root_q + 4'd1;
						nfc_q <= (CB+1)'((13'd1 << root_q) + 13'd2);
						lim_q <= 13'd1 << (root_q + 4'd1);
						epoch_q <= epoch_q + 1'b1;
						clr_eoi_q <= 1'b1;
					end else begin
						acc_q <= acc_put;
						bc_q <= bc_q + 6'(cw_q);
						if (nfc_q <= (CB+1)'(TopCode)) nfc_q <= nfc_q + 1'b1;
						if (nfc_q == lim_q) begin
							cw_q <= cw_q + 4'd1;
							lim_q <= lim_q << 1;
						end
					end
					prefix_q <= CB'(px_q);
				end
				glzw_pkg::ST_EOI: begin
					if (eoi_q) begin
						acc_q <= acc_put;
						if (nout_q == 3'd0) begin
							bc_q <= bc_q + 6'(cw_q);
							nout_q <= 3'd1;
						end else begin
							bc_q <= (bc_q + 6'(cw_q) + 6'd7) & ~6'd7;
							started_q <= 1'b0;
							nout_q <= '0;
						end
					end
				end
				glzw_pkg::ST_OUT: if (m_valid && m_ready) begin
					acc_q <= acc_q >> 8;
					bc_q <= bc_q - 6'd8;
					nout_q <= nout_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_cw_range: assert property (@(posedge clk) disable iff (!arst_n)
		cw_q <= 4'(CB)) else $error("code width overflow");
	a_bc_room: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= 6'd48) else $error("accumulator overflow");
	a_out_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> st_q == glzw_pkg::ST_OUT) else $error("output outside drain");

endmodule

[src/gif_lzw_encoder_core.sv]
// channel | dir | tdata                    | tuser | tlast
// s_axis  | in  | [8:0] pixel              | -     | end_of_image
// m_axis  | out | [7:0] out_byte           | -     | last_of_run
// cfg     | in  | [3:0] min_code_size      | -     | -
// per pixel, a first-probe hit with no byte out steps through accept, hash, read,
// check, end step and drain; a miss adds a write, end of image adds a second end
// step, each further probe adds a read and check of the dictionary memory, each
// byte past the first adds a drain step; an image's first pixel skips the probe
// after reset a clear pass walks HASH_SLOTS entries before the queue is first read,
// and again whenever the 12-bit table tag wraps; m_axis stalls hold the drain while
// a two-entry queue lets input transfers proceed until it is full
module gif_lzw_encoder_core #(
	parameter int HASH_SLOTS = 5003
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,       // min_code_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [8:0] pixel, rest zero
	input  logic        s_axis_tlast,    // end_of_image
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,    // out_byte
	output logic        m_axis_tlast     // last_of_run
);

	logic [3:0] mcs_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mcs_q <= 4'd8;
		else if (cfg_we) mcs_q <= cfg_wdata;
	end

	glzw_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;
	assign in_item.pixel = s_axis_tdata[8:0];
	assign in_item.eoi   = s_axis_tlast;

	glzw_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	glzw_back #(.HashSlots(HASH_SLOTS)) u_back (
		.clk, .arst_n, .min_code_size(mcs_q),
		.q_valid, .q_ready, .q_item,
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_byte(m_axis_tdata), .m_last(m_axis_tlast)
	);

endmodule
